@@ design/ltl_pkg.sv @@
`default_nettype none
package ltl_pkg;

   localparam int unsigned MAX_RESULTS = 4;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_PEND    = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_SYMBOL  = 3'd3,
      MODE_STRING  = 3'd4,
      MODE_DISCARD = 3'd5
   } mode_type;

   localparam logic [1:0] EV_VALUE    = 2'd0;
   localparam logic [1:0] EV_COMPLETE = 2'd1;
   localparam logic [1:0] EV_ERROR    = 2'd2;

   localparam logic [2:0] TK_LPAREN = 3'd0;
   localparam logic [2:0] TK_RPAREN = 3'd1;
   localparam logic [2:0] TK_STRING = 3'd2;
   localparam logic [2:0] TK_NUMBER = 3'd3;
   localparam logic [2:0] TK_SYMBOL = 3'd4;
   localparam logic [2:0] TK_EOF    = 3'd5;

   localparam logic [1:0] ERR_NONE         = 2'd0;
   localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN      = 2'd2;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LESS    = 8'h3C;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_GREATER = 8'h3E;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [15:0] POS_MAX = 16'hFFFF;
   localparam logic [7:0]  COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [2:0]  token_kind;
      logic [7:0]  value_byte;
      logic [15:0] start_line;
      logic [15:0] start_column;
      logic [1:0]  error_code;
      logic        last_of_run;
   } result_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
             ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_sym(input logic [7:0] b);
      return is_digit(b) || is_alpha(b) ||
             (b inside {CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH,
                        CHAR_EQUAL, CHAR_LESS, CHAR_GREATER, CHAR_BANG});
   endfunction

   function automatic logic [15:0] adv_line(input logic [15:0] line,
                                            input logic [7:0] b);
      if ((b == CHAR_NEWLINE) && (line != POS_MAX)) begin
         return line + 16'd1;
      end
      return line;
   endfunction

   function automatic logic [15:0] adv_col(input logic [15:0] col,
                                           input logic [7:0] b);
      if (b == CHAR_NEWLINE) begin
         return 16'd1;
      end else if (col != POS_MAX) begin
         return col + 16'd1;
      end
      return col;
   endfunction

   function automatic result_type make_result(input logic [1:0]  ev,
                                              input logic [2:0]  tk,
                                              input logic [7:0]  val,
                                              input logic [15:0] ln,
                                              input logic [15:0] col,
                                              input logic [1:0]  err);
      result_type r;
      r.event_kind   = ev;
      r.token_kind   = tk;
      r.value_byte   = val;
      r.start_line   = ln;
      r.start_column = col;
      r.error_code   = err;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ design/ltl_channels.sv @@
`default_nettype none
interface ltl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] source_byte;
   logic       end_marker;

   modport source (output valid, output source_byte, output end_marker, input ready);
   modport sink (input valid, input source_byte, input end_marker, output ready);
endinterface

interface ltl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [2:0]  token_kind;
   logic [7:0]  value_byte;
   logic [15:0] start_line;
   logic [15:0] start_column;
   logic [1:0]  error_code;
   logic        last_of_run;

   modport source (output valid, output event_kind, output token_kind,
                   output value_byte, output start_line, output start_column,
                   output error_code, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input token_kind,
                 input value_byte, input start_line, input start_column,
                 input error_code, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ design/lisp_token_lexer.sv @@
`default_nettype none
// streaming s-expression lexer: one source byte (or end marker) per transfer
// on req_chan, results on rsp_chan as value bytes followed by a completion or
// error result, with last_of_run flagging the final result of each byte.
// a byte is taken every cycle while each byte yields at most one result and
// results are taken as offered; a byte with k results (k up to four, e.g. "-5"
// with a limit of one) holds the bank until all k have transferred, and the
// next byte is taken in the cycle its last result transfers. the first result
// is offered in the cycle after its byte. csr writes set max_value_chars and
// are accepted at any time, but must only happen while the lexer is idle.
module lisp_token_lexer (
   input  wire         clock,
   input  wire         reset,
   ltl_req_if.sink     req_chan,
   ltl_rsp_if.source   rsp_chan,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [7:0]   csr_max_value_chars
);
   import ltl_pkg::*;

   // lexer state
   mode_type    mode_ff, mode_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] tline_ff, tline_in;
   logic [15:0] tcol_ff, tcol_in;
   logic [7:0]  max_ff;

   // result bank, drained one result per cycle while rsp_chan is ready
   result_type  bank_ff [MAX_RESULTS];
   result_type  bank_in [MAX_RESULTS];
   logic [2:0]  left_ff, left_in;
   logic [1:0]  rd_ff, rd_in;

   logic [2:0]  nres;
   logic        req_xfer;
   logic        rsp_xfer;

   assign csr_ready = 1'b1;

   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;
   // take a new byte once the bank is empty or its final result is leaving
   assign req_chan.ready = (left_ff == 3'd0) || ((left_ff == 3'd1) && rsp_chan.ready);
   assign req_xfer = req_chan.valid && req_chan.ready;

   // next lexer state and the results of the offered byte
   always_comb begin
      logic [7:0] b;
      logic [7:0] limit;
      logic       fin;
      logic       dig;
      logic       num;
      logic       done;
      logic [2:0] tk;

      b     = req_chan.source_byte;
      fin   = req_chan.end_marker || (b == CHAR_NUL);
      limit = (max_ff == 8'd0) ? 8'd1 : max_ff;
      dig   = 1'b0;
      num   = 1'b0;
      done  = 1'b0;
      tk    = TK_SYMBOL;

      mode_in  = mode_ff;
      count_in = count_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      nres     = 3'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         bank_in[i] = make_result(EV_VALUE, TK_LPAREN, 8'd0, 16'd0, 16'd0, ERR_NONE);
      end

      if (mode_in == MODE_DISCARD) begin
         // swallow bytes until the end marker
         if (fin) begin
            line_in = 16'd0;
            col_in  = 16'd0;
            mode_in = MODE_IDLE;
         end
      end else if (mode_in == MODE_STRING) begin
         if (fin) begin
            bank_in[nres[1:0]] = make_result(EV_ERROR, TK_LPAREN, 8'd0, tline_in,
                                             tcol_in, ERR_UNTERMINATED);
            nres    = nres + 3'd1;
            line_in = 16'd0;
            col_in  = 16'd0;
            mode_in = MODE_IDLE;
         end else if (b == CHAR_QUOTE) begin
            line_in = adv_line(line_in, b);
            col_in  = adv_col(col_in, b);
            bank_in[nres[1:0]] = make_result(EV_COMPLETE, TK_STRING, 8'd0, tline_in,
                                             tcol_in, ERR_NONE);
            nres    = nres + 3'd1;
            mode_in = MODE_IDLE;
         end else begin
            // bytes beyond the limit are dropped but still move the position
            if (count_in < limit) begin
               bank_in[nres[1:0]] = make_result(EV_VALUE, TK_STRING, b, tline_in,
                                                tcol_in, ERR_NONE);
               nres     = nres + 3'd1;
               count_in = count_in + 8'd1;
            end
            line_in = adv_line(line_in, b);
            col_in  = adv_col(col_in, b);
         end
      end else begin
         // a pending minus is resolved by this byte
         if (mode_in == MODE_PEND) begin
            dig = !fin && is_digit(b);
            tk  = dig ? TK_NUMBER : TK_SYMBOL;
            bank_in[nres[1:0]] = make_result(EV_VALUE, tk, CHAR_MINUS, tline_in,
                                             tcol_in, ERR_NONE);
            nres     = nres + 3'd1;
            count_in = 8'd1;
            mode_in  = dig ? MODE_NUMBER : MODE_SYMBOL;
            if (8'd1 >= limit) begin
               bank_in[nres[1:0]] = make_result(EV_COMPLETE, tk, 8'd0, tline_in,
                                                tcol_in, ERR_NONE);
               nres    = nres + 3'd1;
               mode_in = MODE_IDLE;
            end
         end

         // extend or close an open number or symbol
         if ((mode_in == MODE_NUMBER) || (mode_in == MODE_SYMBOL)) begin
            num = (mode_in == MODE_NUMBER);
            tk  = num ? TK_NUMBER : TK_SYMBOL;
            if (!fin && (num ? is_digit(b) : is_sym(b))) begin
               bank_in[nres[1:0]] = make_result(EV_VALUE, tk, b, tline_in,
                                                tcol_in, ERR_NONE);
               nres = nres + 3'd1;
               if (count_in != COUNT_MAX) begin
                  count_in = count_in + 8'd1;
               end
               line_in = adv_line(line_in, b);
               col_in  = adv_col(col_in, b);
               if (count_in >= limit) begin
                  bank_in[nres[1:0]] = make_result(EV_COMPLETE, tk, 8'd0, tline_in,
                                                   tcol_in, ERR_NONE);
                  nres    = nres + 3'd1;
                  mode_in = MODE_IDLE;
               end
               done = 1'b1;
            end else begin
               bank_in[nres[1:0]] = make_result(EV_COMPLETE, tk, 8'd0, tline_in,
                                                tcol_in, ERR_NONE);
               nres    = nres + 3'd1;
               mode_in = MODE_IDLE;
            end
         end

         if (!done) begin
            if (fin) begin
               // end of file at the current position, then back to the start
               bank_in[nres[1:0]] = make_result(EV_COMPLETE, TK_EOF, 8'd0, line_in,
                                                col_in, ERR_NONE);
               nres    = nres + 3'd1;
               line_in = 16'd0;
               col_in  = 16'd0;
               mode_in = MODE_IDLE;
            end else if (is_space(b)) begin
               line_in = adv_line(line_in, b);
               col_in  = adv_col(col_in, b);
            end else begin
               // a new token starts here
               tline_in = line_in;
               tcol_in  = col_in;
               count_in = 8'd0;
               if ((b == CHAR_LPAREN) || (b == CHAR_RPAREN)) begin
                  tk = (b == CHAR_LPAREN) ? TK_LPAREN : TK_RPAREN;
                  bank_in[nres[1:0]] = make_result(EV_VALUE, tk, b, tline_in,
                                                   tcol_in, ERR_NONE);
                  nres    = nres + 3'd1;
                  line_in = adv_line(line_in, b);
                  col_in  = adv_col(col_in, b);
                  bank_in[nres[1:0]] = make_result(EV_COMPLETE, tk, 8'd0, tline_in,
                                                   tcol_in, ERR_NONE);
                  nres    = nres + 3'd1;
                  mode_in = MODE_IDLE;
               end else if (b == CHAR_QUOTE) begin
                  mode_in = MODE_STRING;
                  line_in = adv_line(line_in, b);
                  col_in  = adv_col(col_in, b);
               end else if (b == CHAR_MINUS) begin
                  // decided by the following byte
                  mode_in = MODE_PEND;
                  line_in = adv_line(line_in, b);
                  col_in  = adv_col(col_in, b);
               end else if (is_sym(b)) begin
                  tk      = is_digit(b) ? TK_NUMBER : TK_SYMBOL;
                  mode_in = is_digit(b) ? MODE_NUMBER : MODE_SYMBOL;
                  bank_in[nres[1:0]] = make_result(EV_VALUE, tk, b, tline_in,
                                                   tcol_in, ERR_NONE);
                  nres     = nres + 3'd1;
                  count_in = 8'd1;
                  line_in  = adv_line(line_in, b);
                  col_in   = adv_col(col_in, b);
                  if (count_in >= limit) begin
                     bank_in[nres[1:0]] = make_result(EV_COMPLETE, tk, 8'd0, tline_in,
                                                      tcol_in, ERR_NONE);
                     nres    = nres + 3'd1;
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  // unknown byte: report it, then discard up to the end marker
                  bank_in[nres[1:0]] = make_result(EV_ERROR, TK_LPAREN, 8'd0, tline_in,
                                                   tcol_in, ERR_UNKNOWN);
                  nres    = nres + 3'd1;
                  mode_in = MODE_DISCARD;
               end
            end
         end
      end

      // flag the final result of this byte
      for (int i = 0; i < MAX_RESULTS; i++) begin
         bank_in[i].last_of_run = (nres == 3'(i + 1));
      end
   end

   // result bank bookkeeping
   always_comb begin
      left_in = left_ff;
      rd_in   = rd_ff;
      if (req_xfer) begin
         left_in = nres;
         rd_in   = 2'd0;
      end else if (rsp_xfer) begin
         left_in = left_ff - 3'd1;
         rd_in   = rd_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= 8'd0;
         line_ff  <= 16'd0;
         col_ff   <= 16'd0;
         tline_ff <= 16'd0;
         tcol_ff  <= 16'd0;
         max_ff   <= COUNT_MAX;
         left_ff  <= 3'd0;
         rd_ff    <= 2'd0;
      end else begin
         if (req_xfer) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            tline_ff <= tline_in;
            tcol_ff  <= tcol_in;
         end
         if (csr_valid && csr_ready) begin
            max_ff <= csr_max_value_chars;
         end
         left_ff <= left_in;
         rd_ff   <= rd_in;
      end
   end

   // payload of the bank, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            bank_ff[i] <= bank_in[i];
         end
      end
   end

   // result channel drive
   always_comb begin
      rsp_chan.valid        = (left_ff != 3'd0);
      rsp_chan.event_kind   = bank_ff[rd_ff].event_kind;
      rsp_chan.token_kind   = bank_ff[rd_ff].token_kind;
      rsp_chan.value_byte   = bank_ff[rd_ff].value_byte;
      rsp_chan.start_line   = bank_ff[rd_ff].start_line;
      rsp_chan.start_column = bank_ff[rd_ff].start_column;
      rsp_chan.error_code   = bank_ff[rd_ff].error_code;
      rsp_chan.last_of_run  = bank_ff[rd_ff].last_of_run;
   end

endmodule
`default_nettype wire
